FILE: sv/nks_pkg.sv
// Shared types and constants of the nearest keyframe selector.
`timescale 1ns / 1ps

package nks_pkg;

    localparam int AZ_W    = 15;
    localparam int ALT_W   = 14;
    localparam int TIME_W  = 16;
    localparam int SLOT_W  = 7;
    localparam int DIST_W  = 31;
    localparam int COUNT_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic MODE_SUN  = 1'b0;
    localparam logic MODE_TIME = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd1;

    // Query operands, held steady for the whole walk down the chain.
    typedef struct packed {
        logic                     mode;
        logic [AZ_W-1:0]          az;
        logic signed [ALT_W-1:0]  alt;
        logic [TIME_W-1:0]        tq;
    } query_t;

    // Search token that moves from one cell to the next.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [DIST_W-1:0] best_dist;
    } token_t;

endpackage

FILE: sv/nks_item_if.sv
// Input item channel of the nearest keyframe selector.
`timescale 1ns / 1ps

interface nks_item_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic [nks_pkg::SLOT_W-1:0]           entry_index;
    logic [nks_pkg::AZ_W-1:0]             azimuth_value;
    logic signed [nks_pkg::ALT_W-1:0]     altitude_value;
    logic [nks_pkg::TIME_W-1:0]           day_fraction;

    modport source (
        output valid, cmd, entry_index, azimuth_value, altitude_value, day_fraction,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, azimuth_value, altitude_value, day_fraction,
        output ready
    );
endinterface

FILE: sv/nks_result_if.sv
// Result channel of the nearest keyframe selector.
`timescale 1ns / 1ps

interface nks_result_if;
    logic                       valid;
    logic                       ready;
    logic [nks_pkg::SLOT_W-1:0] best_index;

    modport source (
        output valid, best_index,
        input  ready
    );
    modport sink (
        input  valid, best_index,
        output ready
    );
endinterface

FILE: sv/nks_cfg_if.sv
// Configuration write channel of the nearest keyframe selector.
`timescale 1ns / 1ps

interface nks_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [nks_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [nks_pkg::CFG_DATA_W-1:0] write_data;

    modport source (
        output valid, reg_index, write_data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, write_data,
        output ready
    );
endinterface

FILE: sv/nks_cell.sv
// One keyframe cell: stores an entry and updates the passing search token.
`timescale 1ns / 1ps

module nks_cell #(
    parameter int IDX    = 0,
    parameter int SLOT_W = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [nks_pkg::SLOT_W-1:0]       wr_slot,
    input  logic [nks_pkg::AZ_W-1:0]         wr_az,
    input  logic signed [nks_pkg::ALT_W-1:0] wr_alt,
    input  logic [nks_pkg::TIME_W-1:0]       wr_tm,
    input  nks_pkg::query_t                  query,
    input  logic [nks_pkg::COUNT_W-1:0]      entry_count,
    input  nks_pkg::token_t                  tok_in,
    input  logic [SLOT_W-1:0]                idx_in,
    output nks_pkg::token_t                  tok_out,
    output logic [SLOT_W-1:0]                idx_out
);

    logic [nks_pkg::AZ_W-1:0]         az_reg;
    logic signed [nks_pkg::ALT_W-1:0] alt_reg;
    logic [nks_pkg::TIME_W-1:0]       tm_reg;

    nks_pkg::token_t            tok_next;
    logic                       valid_reg;
    logic                       found_reg;
    logic [nks_pkg::DIST_W-1:0] best_dist_reg;
    logic [SLOT_W-1:0]          idx_reg;
    logic [SLOT_W-1:0]          idx_next;

    logic                          active;
    logic                          take;
    logic [nks_pkg::AZ_W:0]        daz;
    logic [nks_pkg::ALT_W:0]       dalt;
    logic [nks_pkg::AZ_W-1:0]      uaz;
    logic [nks_pkg::ALT_W-1:0]     ualt;
    logic [2*nks_pkg::AZ_W-1:0]    sq_az;
    logic [2*nks_pkg::ALT_W-1:0]   sq_alt;
    logic [nks_pkg::TIME_W-1:0]    dtm;
    logic [nks_pkg::DIST_W-1:0]    cand_dist;

    always_ff @(posedge clk)
    begin
        if (wr_en && (32'(wr_slot) == 32'(IDX)))
        begin
            az_reg  <= wr_az;
            alt_reg <= wr_alt;
            tm_reg  <= wr_tm;
        end
    end

    // Differences are taken one bit wider so that the sign is kept.
    assign daz  = {1'b0, az_reg} - {1'b0, query.az};
    assign dalt = {alt_reg[nks_pkg::ALT_W-1], alt_reg} - {query.alt[nks_pkg::ALT_W-1], query.alt};
    assign uaz  = daz[nks_pkg::AZ_W] ? nks_pkg::AZ_W'(-daz) : daz[nks_pkg::AZ_W-1:0];
    assign ualt = dalt[nks_pkg::ALT_W] ? nks_pkg::ALT_W'(-dalt) : dalt[nks_pkg::ALT_W-1:0];
    assign sq_az  = (2*nks_pkg::AZ_W)'(uaz) * (2*nks_pkg::AZ_W)'(uaz);
    assign sq_alt = (2*nks_pkg::ALT_W)'(ualt) * (2*nks_pkg::ALT_W)'(ualt);
    assign dtm  = (tm_reg > query.tq) ? (tm_reg - query.tq) : (query.tq - tm_reg);

    always_comb
    begin
        if (query.mode == nks_pkg::MODE_TIME)
            cand_dist = nks_pkg::DIST_W'(dtm);
        else
            cand_dist = nks_pkg::DIST_W'(sq_az) + nks_pkg::DIST_W'(sq_alt);
    end

    assign active = 32'(entry_count) > 32'(IDX);
    assign take   = tok_in.valid && active && (!tok_in.found || (cand_dist < tok_in.best_dist));

    always_comb
    begin
        tok_next.valid     = tok_in.valid;
        tok_next.found     = tok_in.found | take;
        tok_next.best_dist = take ? cand_dist : tok_in.best_dist;
        idx_next           = take ? SLOT_W'(IDX) : idx_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg     <= tok_next.found;
        best_dist_reg <= tok_next.best_dist;
        idx_reg       <= idx_next;
    end

    always_comb
    begin
        tok_out.valid     = valid_reg;
        tok_out.found     = found_reg;
        tok_out.best_dist = best_dist_reg;
    end

    assign idx_out = idx_reg;

endmodule

FILE: sv/nearest_keyframe_selector_core.sv
// Top level of the nearest keyframe selector: cell chain, control and ports.
`timescale 1ns / 1ps

// The block keeps up to MAX_ENTRIES keyframes in a row of cells, one entry
// per cell, and answers a query with the index of the nearest entry among
// the first entry_count entries (squared angle distance in sun mode,
// absolute time difference in time mode; ties keep the lower index; an
// empty table answers 0). A write item gives no result, so writes can
// follow each other every cycle while the item side is open. A query
// launches a search token through start_reg, then the register of each
// cell in turn, one cell per clock, and then the output register that
// drives result.valid. While a query is in flight, or while its result
// waits in the output register, no new item is taken, so a new query is
// taken only once the result of the one before has been taken.
// Configuration writes are taken at any time, but are meant to be made
// only while the block is idle. Entries must be written before a query
// reaches them.
module nearest_keyframe_selector_core #(
    parameter int MAX_ENTRIES = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    nks_cfg_if.sink       cfg,
    nks_item_if.sink      item,
    nks_result_if.source  result
);

    localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic                               select_mode_reg;
    logic [nks_pkg::COUNT_W-1:0]        entry_count_reg;
    nks_pkg::query_t                    query_reg;
    logic                               busy_reg;
    logic                               start_reg;
    logic                               out_valid_reg;
    logic [nks_pkg::SLOT_W-1:0]         best_index_reg;

    logic item_xfer;
    logic query_xfer;
    logic wr_en;
    logic done;

    nks_pkg::token_t   tok [0:MAX_ENTRIES];
    logic [SLOT_W-1:0] idx [0:MAX_ENTRIES];

    // The item side stays closed while a search runs or a result waits.
    assign item.ready  = !busy_reg && !out_valid_reg;
    assign cfg.ready   = 1'b1;
    assign item_xfer   = item.valid && item.ready;
    assign query_xfer  = item_xfer && (item.cmd == nks_pkg::CMD_QUERY);
    // Writes to slots past the table size are dropped.
    assign wr_en       = item_xfer && (item.cmd == nks_pkg::CMD_WRITE)
                         && (32'(item.entry_index) < 32'(MAX_ENTRIES));
    assign done        = tok[MAX_ENTRIES].valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_mode_reg <= nks_pkg::MODE_SUN;
            entry_count_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.reg_index)
                nks_pkg::REG_SELECT_MODE: select_mode_reg <= cfg.write_data[0];
                nks_pkg::REG_ENTRY_COUNT: entry_count_reg <= cfg.write_data;
                default: ;
            endcase
        end
    end

    // Query operands are captured once and broadcast to every cell. The mode
    // is taken along; it cannot change while a search runs.
    always_ff @(posedge clk)
    begin
        if (query_xfer)
        begin
            query_reg.mode <= select_mode_reg;
            query_reg.az   <= item.azimuth_value;
            query_reg.alt  <= item.altitude_value;
            query_reg.tq   <= item.day_fraction;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= query_xfer;
            if (query_xfer)
                busy_reg <= 1'b1;
            else if (done)
                busy_reg <= 1'b0;
            if (done)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
            best_index_reg <= nks_pkg::SLOT_W'(idx[MAX_ENTRIES]);
    end

    assign result.valid      = out_valid_reg;
    assign result.best_index = best_index_reg;

    // The token enters the chain with no candidate found yet.
    always_comb
    begin
        tok[0].valid     = start_reg;
        tok[0].found     = 1'b0;
        tok[0].best_dist = '0;
        idx[0]           = '0;
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        nks_cell #(
            .IDX    (g),
            .SLOT_W (SLOT_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .wr_en       (wr_en),
            .wr_slot     (item.entry_index),
            .wr_az       (item.azimuth_value),
            .wr_alt      (item.altitude_value),
            .wr_tm       (item.day_fraction),
            .query       (query_reg),
            .entry_count (entry_count_reg),
            .tok_in      (tok[g]),
            .idx_in      (idx[g]),
            .tok_out     (tok[g+1]),
            .idx_out     (idx[g+1])
        );
    end

endmodule

FILE: sv/nks_checker.sv
// Port-level assertions for the nearest keyframe selector, bound to the top level.
`timescale 1ns / 1ps

module nks_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_cmd,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic [nks_pkg::SLOT_W-1:0] res_index
);

    // A pending result is held until it is taken.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_index)))
        else $error("result dropped or changed while stalled");

    // No item is taken while a result waits.
    a_no_take_pending: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !in_ready)
        else $error("item side open while a result waits");

    // A query never answers in the very next cycle.
    a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_cmd == nks_pkg::CMD_QUERY)) |=> !res_valid)
        else $error("query answered too early");

    // A write produces no result.
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_cmd == nks_pkg::CMD_WRITE)) |=> !res_valid)
        else $error("write produced a result");

endmodule

bind nearest_keyframe_selector_core nks_checker u_nks_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_cmd    (item.cmd),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_index (result.best_index)
);
